[src/mmm_pkg.sv]
// shared types, constants and arithmetic helpers for the motor mixer
package mmm_pkg;

    localparam int MAX_MOTORS_DEF = 8;
    localparam int OFF_DRIVE_DEF  = 0;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DVD_W      = 32;
    localparam int DSR_W      = 17;
    localparam int PROD_W     = 43;
    localparam int SEED_SCALE = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTOR_COUNT,
        REG_DRIVE_MIN,
        REG_DRIVE_MAX,
        REG_STICK_THRESHOLD,
        REG_UNIT_SCALE,
        REG_ROLL_COEFS,
        REG_PITCH_COEFS,
        REG_YAW_COEFS
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0]         motor_count;
        logic [11:0]        drive_min;
        logic [11:0]        drive_max;
        logic signed [12:0] stick_threshold;
        logic [7:0]         unit_scale;
        logic [63:0]        roll_coefs;
        logic [63:0]        pitch_coefs;
        logic [63:0]        yaw_coefs;
    } cfg_t;

    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] r;
        if (v > 43'sd32767)
            r = 16'sh7fff;
        else if (v < -43'sd32768)
            r = -16'sd32768;
        else
            r = 16'(v);
        return r;
    endfunction

    // divide by 16384 truncating toward zero, then saturate
    function automatic logic signed [15:0] scale_term(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p + ((p < 0) ? 43'sd16383 : 43'sd0);
        return sat16(b >>> 14);
    endfunction

    function automatic logic [11:0] clamp_drive(input logic signed [19:0] v,
                                                input logic [11:0] mn,
                                                input logic [11:0] mx);
        logic signed [19:0] r;
        r = v;
        if (r < $signed({8'd0, mn}))
            r = $signed({8'd0, mn});
        if (r > $signed({8'd0, mx}))
            r = $signed({8'd0, mx});
        return r[11:0];
    endfunction

endpackage

[src/mmm_div.sv]
// iterative signed divider, one quotient bit per cycle, truncates toward zero
module mmm_div
    import mmm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic signed [DSR_W-1:0] divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            dsr_reg <= divisor[DSR_W-1] ? DSR_W'(-divisor) : DSR_W'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[DVD_W-1] ^ divisor[DSR_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DSR_W])
            begin
                rem_reg <= trial[DSR_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DSR_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

[src/mmm_cfg.sv]
// configuration register file
module mmm_cfg
    import mmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_count     <= 4'd4;
            cfg_reg.drive_min       <= 12'd0;
            cfg_reg.drive_max       <= 12'd2000;
            cfg_reg.stick_threshold <= 13'sd0;
            cfg_reg.unit_scale      <= 8'd10;
            cfg_reg.roll_coefs      <= '0;
            cfg_reg.pitch_coefs     <= '0;
            cfg_reg.yaw_coefs       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MOTOR_COUNT:     cfg_reg.motor_count     <= cfg_data[3:0];
                REG_DRIVE_MIN:       cfg_reg.drive_min       <= cfg_data[11:0];
                REG_DRIVE_MAX:       cfg_reg.drive_max       <= cfg_data[11:0];
                REG_STICK_THRESHOLD: cfg_reg.stick_threshold <= $signed(cfg_data[12:0]);
                REG_UNIT_SCALE:      cfg_reg.unit_scale      <= cfg_data[7:0];
                REG_ROLL_COEFS:      cfg_reg.roll_coefs      <= cfg_data;
                REG_PITCH_COEFS:     cfg_reg.pitch_coefs     <= cfg_data;
                REG_YAW_COEFS:       cfg_reg.yaw_coefs       <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/multirotor_motor_mixer_unit.sv]
// Multirotor motor mixer: one input beat gives one result beat per motor, motor 0 first.
// Items are handled one at a time; in_stall is high from acceptance until the last
// result beat is taken. A disarmed item only emits off beats, back to back while
// out_stall stays low. An armed item with the stick at or above the threshold runs
// throttle compensation through the shared divider, once per nonzero cosine; every
// armed item then forms the mixing terms of each motor on the shared multiplier, and
// then per motor takes a plain add, shift or zero-ceiling branch, or a scaled branch
// (multiplier plus divider), before its result beat.
module multirotor_motor_mixer_unit
    import mmm_pkg::*;
#(
    parameter int MAX_MOTORS = MAX_MOTORS_DEF,
    parameter int OFF_DRIVE  = OFF_DRIVE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  armed,
    input  logic signed [12:0]    throttle_stick,
    input  logic signed [15:0]    roll_cosine,
    input  logic signed [15:0]    pitch_cosine,
    input  logic signed [15:0]    roll_demand,
    input  logic signed [15:0]    pitch_demand,
    input  logic signed [15:0]    yaw_demand,
    input  logic signed [15:0]    climb_demand,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            motor_index,
    output logic [11:0]           drive,
    output logic                  flight_active,
    output logic                  stop_command,
    output logic                  last
);

    localparam int IDX_W = $clog2(MAX_MOTORS);
    localparam int CNT_W = $clog2(MAX_MOTORS + 1);
    localparam logic [11:0] OFF_VAL = 12'(OFF_DRIVE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR_R,
        S_THR_P,
        S_MIX,
        S_FIT,
        S_OUT
    } state_t;

    cfg_t cfg;

    mmm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    state_t             state_reg;
    logic [3:0]         step_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [15:0] thr_reg;
    logic signed [15:0] max1_reg;
    logic signed [15:0] max2_reg;
    logic               out_valid_reg;
    logic [2:0]         idx_reg;
    logic [11:0]        drv_reg;
    logic               flying_reg;
    logic               stop_reg;
    logic               last_reg;

    // datapath payload
    logic signed [12:0]       stick_reg;
    logic signed [15:0]       rcos_reg;
    logic signed [15:0]       pcos_reg;
    logic signed [15:0]       rd_reg;
    logic signed [15:0]       pd_reg;
    logic signed [15:0]       yd_reg;
    logic signed [15:0]       cd_reg;
    logic signed [24:0]       acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [15:0]       term_reg;
    logic signed [15:0]       t1_reg [MAX_MOTORS];
    logic signed [15:0]       t2_reg [MAX_MOTORS];

    logic                     in_accept;
    logic [CNT_W-1:0]         cnt_eff;
    logic [14:0]              sc100;
    logic signed [15:0]       max_seed;
    logic [IDX_W-1:0]         nidx;
    logic [2:0]               msel;
    logic signed [7:0]        rc;
    logic signed [7:0]        pc;
    logic signed [7:0]        yc;
    logic signed [16:0]       sc_s;
    logic signed [16:0]       mx_s;
    logic signed [17:0]       mx18;
    logic signed [17:0]       sum1;
    logic signed [17:0]       sum_all;
    logic signed [17:0]       gap;
    logic                     br_all;
    logic                     br_sec;
    logic                     br_pri;
    logic signed [15:0]       t1n;
    logic signed [15:0]       t2n;
    logic signed [19:0]       q20;
    logic signed [19:0]       v_fast;
    logic signed [19:0]       v_slow;

    logic signed [25:0]       mul_a;
    logic signed [16:0]       mul_b;
    logic                     div_start;
    logic signed [DVD_W-1:0]  div_dvd;
    logic signed [DSR_W-1:0]  div_dsr;
    logic                     div_done;
    logic signed [DVD_W-1:0]  div_q;

    mmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_accept = in_valid & ~in_stall;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        if (cfg.motor_count == 4'd0)
            cnt_eff = CNT_W'(1);
        else if (32'(cfg.motor_count) > MAX_MOTORS)
            cnt_eff = CNT_W'(MAX_MOTORS);
        else
            cnt_eff = CNT_W'(cfg.motor_count);
    end

    assign sc100    = 15'(cfg.unit_scale) * 15'(SEED_SCALE);
    assign max_seed = -$signed({1'b0, sc100});

    assign nidx = n_reg[IDX_W-1:0];
    assign msel = 3'(n_reg);
    assign rc   = $signed(cfg.roll_coefs[8*msel +: 8]);
    assign pc   = $signed(cfg.pitch_coefs[8*msel +: 8]);
    assign yc   = $signed(cfg.yaw_coefs[8*msel +: 8]);
    assign sc_s = $signed({9'd0, cfg.unit_scale});
    assign mx_s = $signed({5'd0, cfg.drive_max});
    assign mx18 = $signed({6'd0, cfg.drive_max});

    // fitting branch selection, stable across one motor
    assign sum1    = 18'(max1_reg) + 18'(thr_reg);
    assign sum_all = sum1 + 18'(max2_reg);
    assign gap     = mx18 - sum1;
    assign br_all  = sum_all < mx18;
    assign br_sec  = sum1 < mx18;
    assign br_pri  = 18'(max1_reg) < mx18;

    assign t1n    = t1_reg[nidx];
    assign t2n    = t2_reg[nidx];
    // scaled term can lie far outside the drive range, limit it before the add
    assign q20    = (div_q > 32'sd262143)  ? 20'sd262143 :
                    (div_q < -32'sd262144) ? -20'sd262144 : 20'(div_q);
    assign v_fast = br_all ? 20'(t1n) + 20'(t2n) + 20'(thr_reg)
                           : 20'(t1n) + 20'(mx18 - 18'(max1_reg));
    assign v_slow = br_sec ? 20'(t1n) + 20'(thr_reg) + q20 : q20;

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
        case (state_reg)
            S_THR_R:
            begin
                div_start = (step_reg == 4'd0) && (rcos_reg != 16'sd0);
                div_dvd   = 32'(stick_reg) <<< 14;
                div_dsr   = 17'(rcos_reg);
            end
            S_THR_P:
            begin
                div_start = (step_reg == 4'd0) && (pcos_reg != 16'sd0);
                div_dvd   = 32'(thr_reg) <<< 14;
                div_dsr   = 17'(pcos_reg);
            end
            S_MIX:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = 26'(pd_reg);
                        mul_b = 17'(pc);
                    end
                    4'd1:
                    begin
                        mul_a = 26'(rd_reg);
                        mul_b = 17'(rc);
                    end
                    4'd3, 4'd7:
                    begin
                        mul_a = 26'(acc_reg);
                        mul_b = sc_s;
                    end
                    4'd5:
                    begin
                        mul_a = 26'(yd_reg);
                        mul_b = 17'(yc);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_FIT:
            begin
                if (br_sec)
                begin
                    mul_a = 26'(t2n);
                    mul_b = 17'(gap);
                    div_dsr = 17'(max2_reg);
                end
                else
                begin
                    mul_a = 26'(t1n);
                    mul_b = mx_s;
                    div_dsr = 17'(max1_reg);
                end
                div_start = (step_reg == 4'd1);
                div_dvd   = 32'(prod_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a * mul_b);
        if (in_accept)
        begin
            stick_reg <= throttle_stick;
            rcos_reg  <= roll_cosine;
            pcos_reg  <= pitch_cosine;
            rd_reg    <= roll_demand;
            pd_reg    <= pitch_demand;
            yd_reg    <= yaw_demand;
            cd_reg    <= climb_demand;
        end
        if (state_reg == S_MIX)
        begin
            case (step_reg)
                4'd1:    acc_reg <= 25'(prod_reg);
                4'd2:    acc_reg <= acc_reg - 25'(prod_reg);
                4'd4:    term_reg <= scale_term(prod_reg);
                4'd5:    t1_reg[nidx] <= term_reg;
                4'd6:    acc_reg <= (25'(cd_reg) <<< 6) + 25'(prod_reg);
                4'd8:    term_reg <= scale_term(prod_reg);
                4'd9:    t2_reg[nidx] <= term_reg;
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            thr_reg       <= '0;
            max1_reg      <= '0;
            max2_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            drv_reg       <= '0;
            flying_reg    <= 1'b0;
            stop_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        cnt_reg  <= cnt_eff;
                        n_reg    <= '0;
                        step_reg <= '0;
                        max1_reg <= max_seed;
                        max2_reg <= max_seed;
                        if (!armed)
                        begin
                            flying_reg    <= 1'b0;
                            stop_reg      <= 1'b1;
                            drv_reg       <= OFF_VAL;
                            idx_reg       <= '0;
                            last_reg      <= (cnt_eff == CNT_W'(1));
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            stop_reg <= 1'b0;
                            if (throttle_stick < cfg.stick_threshold)
                            begin
                                flying_reg <= 1'b0;
                                thr_reg    <= $signed({4'd0, cfg.drive_min});
                                state_reg  <= S_MIX;
                            end
                            else
                            begin
                                flying_reg <= 1'b1;
                                thr_reg    <= 16'(throttle_stick);
                                state_reg  <= S_THR_R;
                            end
                        end
                    end
                end
                S_THR_R, S_THR_P:
                begin
                    if (step_reg == 4'd0)
                    begin
                        if (div_start)
                            step_reg <= 4'd1;
                        else
                            state_reg <= (state_reg == S_THR_R) ? S_THR_P : S_MIX;
                    end
                    else if (div_done)
                    begin
                        thr_reg   <= sat16(PROD_W'(div_q));
                        step_reg  <= '0;
                        state_reg <= (state_reg == S_THR_R) ? S_THR_P : S_MIX;
                    end
                end
                S_MIX:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd5 && term_reg > max1_reg)
                        max1_reg <= term_reg;
                    if (step_reg == 4'd9)
                    begin
                        if (term_reg > max2_reg)
                            max2_reg <= term_reg;
                        step_reg <= '0;
                        if (n_reg + 1'b1 == cnt_reg)
                        begin
                            n_reg     <= '0;
                            state_reg <= S_FIT;
                        end
                        else
                            n_reg <= n_reg + 1'b1;
                    end
                end
                S_FIT:
                begin
                    case (step_reg)
                        4'd0:
                        begin
                            if (br_all || (!br_sec && br_pri) ||
                                (!br_sec && !br_pri && max1_reg == 16'sd0))
                            begin
                                // shift and add branches, or zero ceiling
                                drv_reg <= (br_all || br_pri)
                                           ? clamp_drive(v_fast, cfg.drive_min,
                                                         cfg.drive_max)
                                           : clamp_drive(20'sd0, cfg.drive_min,
                                                         cfg.drive_max);
                                idx_reg       <= 3'(n_reg);
                                last_reg      <= (n_reg + 1'b1 == cnt_reg);
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                            else
                                step_reg <= 4'd1;
                        end
                        4'd1:
                            step_reg <= 4'd2;
                        default:
                        begin
                            if (div_done)
                            begin
                                drv_reg <= clamp_drive(v_slow, cfg.drive_min,
                                                       cfg.drive_max);
                                idx_reg       <= 3'(n_reg);
                                last_reg      <= (n_reg + 1'b1 == cnt_reg);
                                out_valid_reg <= 1'b1;
                                step_reg      <= '0;
                                state_reg     <= S_OUT;
                            end
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (last_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            n_reg <= n_reg + 1'b1;
                            if (stop_reg)
                            begin
                                idx_reg  <= 3'(n_reg + 1'b1);
                                last_reg <= (n_reg + CNT_W'(2) == cnt_reg);
                                drv_reg  <= OFF_VAL;
                            end
                            else
                            begin
                                out_valid_reg <= 1'b0;
                                step_reg      <= '0;
                                state_reg     <= S_FIT;
                            end
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_index   = idx_reg;
    assign drive         = drv_reg;
    assign flight_active = flying_reg;
    assign stop_command  = stop_reg;
    assign last          = last_reg;

endmodule

[verif/tb_multirotor_motor_mixer_unit.sv]
// self-checking testbench for the multirotor motor mixer with random config phases and idling
module tb_multirotor_motor_mixer_unit;
    import mmm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic               armed;
        logic signed [12:0] stick;
        logic signed [15:0] roll_cos;
        logic signed [15:0] pitch_cos;
        logic signed [15:0] roll_dem;
        logic signed [15:0] pitch_dem;
        logic signed [15:0] yaw_dem;
        logic signed [15:0] climb_dem;
    } mixer_item_t;

    typedef struct {
        logic [2:0]  idx;
        logic [11:0] drv;
        logic        flying;
        logic        stop;
        logic        final_motor;
    } motor_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  armed;
    logic signed [12:0]    throttle_stick;
    logic signed [15:0]    roll_cosine;
    logic signed [15:0]    pitch_cosine;
    logic signed [15:0]    roll_demand;
    logic signed [15:0]    pitch_demand;
    logic signed [15:0]    yaw_demand;
    logic signed [15:0]    climb_demand;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            motor_index;
    logic [11:0]           drive;
    logic                  flight_active;
    logic                  stop_command;
    logic                  last;

    multirotor_motor_mixer_unit dut (.*);

    cfg_t          mix_cfg;
    mixer_item_t   pending_items[$];
    motor_beat_t   expected_drives[$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            beats_checked = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    bit            no_idle = 0;
    bit            drain_first = 0;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // mixes one item under the current register mirror and queues the motor beats
    function automatic void mix_motors(mixer_item_t it);
        int     cnt;
        longint sc, mx, mn, thr, max1, max2, rc, pc, yc, v;
        longint t1[8];
        longint t2[8];
        logic [11:0] drv[8];
        bit     flying;
        motor_beat_t b;
        cnt = mix_cfg.motor_count;
        if (cnt < 1)
            cnt = 1;
        if (cnt > 8)
            cnt = 8;
        flying = 0;
        sc = mix_cfg.unit_scale;
        mx = mix_cfg.drive_max;
        mn = mix_cfg.drive_min;
        if (it.armed)
        begin
            max1 = -100 * sc;
            max2 = -100 * sc;
            if (longint'(it.stick) < longint'(mix_cfg.stick_threshold))
                thr = mn;
            else
            begin
                flying = 1;
                thr = it.stick;
                if (it.roll_cos != 0)
                    thr = clip16(thr * 16384 / longint'(it.roll_cos));
                if (it.pitch_cos != 0)
                    thr = clip16(thr * 16384 / longint'(it.pitch_cos));
            end
            for (int n = 0; n < cnt; n++)
            begin
                rc = longint'($signed(mix_cfg.roll_coefs[8*n +: 8]));
                pc = longint'($signed(mix_cfg.pitch_coefs[8*n +: 8]));
                yc = longint'($signed(mix_cfg.yaw_coefs[8*n +: 8]));
                t1[n] = clip16((pc * it.pitch_dem - rc * it.roll_dem) * sc / 16384);
                t2[n] = clip16((longint'(it.climb_dem) * 64 + yc * it.yaw_dem) * sc / 16384);
                if (t1[n] > max1)
                    max1 = t1[n];
                if (t2[n] > max2)
                    max2 = t2[n];
            end
            for (int n = 0; n < cnt; n++)
            begin
                if (max1 + max2 + thr < mx)
                    v = t1[n] + t2[n] + thr;
                else if (max1 + thr < mx)
                    v = t1[n] + thr + t2[n] * (mx - max1 - thr) / max2;
                else if (max1 < mx)
                    v = t1[n] + (mx - max1);
                else
                    v = (max1 != 0) ? t1[n] * mx / max1 : 0;
                if (v < mn)
                    v = mn;
                if (v > mx)
                    v = mx;
                drv[n] = v[11:0];
            end
        end
        else
        begin
            for (int n = 0; n < cnt; n++)
                drv[n] = 12'(OFF_DRIVE_DEF);
        end
        for (int n = 0; n < cnt; n++)
        begin
            b.idx = n[2:0];
            b.drv = drv[n];
            b.flying = flying;
            b.stop = !it.armed;
            b.final_motor = (n + 1 == cnt);
            expected_drives.push_back(b);
        end
    endfunction

    // driver: one assignment to in_valid per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            armed <= 0;
            throttle_stick <= '0;
            roll_cosine <= '0;
            pitch_cosine <= '0;
            roll_demand <= '0;
            pitch_demand <= '0;
            yaw_demand <= '0;
            climb_demand <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                mix_motors('{armed, throttle_stick, roll_cosine, pitch_cosine,
                             roll_demand, pitch_demand, yaw_demand, climb_demand});
                items_sent++;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 0;
            end
            else if (pending_items.size() == 0 || (drain_first && expected_drives.size() != 0))
                in_valid <= 0;
            else
            begin
                mixer_item_t it;
                it = pending_items.pop_front();
                in_valid <= 1;
                armed <= it.armed;
                throttle_stick <= it.stick;
                roll_cosine <= it.roll_cos;
                pitch_cosine <= it.pitch_cos;
                roll_demand <= it.roll_dem;
                pitch_demand <= it.pitch_dem;
                yaw_demand <= it.yaw_dem;
                climb_demand <= it.climb_dem;
                send_gap = gap_len();
                // now and then hold the next beat until every motor beat is back
                drain_first = ($urandom_range(0, 24) == 0);
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_drives.size() == 0)
                begin
                    $error("motor beat with nothing expected: motor %0d drive %0d",
                           motor_index, drive);
                    mismatch_count++;
                end
                else
                begin
                    motor_beat_t e;
                    e = expected_drives.pop_front();
                    beats_checked++;
                    if (motor_index !== e.idx)
                    begin
                        $error("motor_index expected %0d actual %0d", e.idx, motor_index);
                        mismatch_count++;
                    end
                    if (drive !== e.drv)
                    begin
                        $error("drive expected %0d actual %0d", e.drv, drive);
                        mismatch_count++;
                    end
                    if (flight_active !== e.flying)
                    begin
                        $error("flight_active expected %0d actual %0d", e.flying, flight_active);
                        mismatch_count++;
                    end
                    if (stop_command !== e.stop)
                    begin
                        $error("stop_command expected %0d actual %0d", e.stop, stop_command);
                        mismatch_count++;
                    end
                    if (last !== e.final_motor)
                    begin
                        $error("last expected %0d actual %0d", e.final_motor, last);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1;
            end
            else
            begin
                stall_left = gap_len();
                out_stall <= (stall_left > 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MOTOR_COUNT:     mix_cfg.motor_count = val[3:0];
            REG_DRIVE_MIN:       mix_cfg.drive_min = val[11:0];
            REG_DRIVE_MAX:       mix_cfg.drive_max = val[11:0];
            REG_STICK_THRESHOLD: mix_cfg.stick_threshold = val[12:0];
            REG_UNIT_SCALE:      mix_cfg.unit_scale = val[7:0];
            REG_ROLL_COEFS:      mix_cfg.roll_coefs = val;
            REG_PITCH_COEFS:     mix_cfg.pitch_coefs = val;
            default:             mix_cfg.yaw_coefs = val;
        endcase
        @(posedge clk);
        cfg_write <= 0;
    endtask

    task automatic set_mixer(int mc, int mn, int mx, int th, int sc,
                             logic [63:0] rcf, logic [63:0] pcf, logic [63:0] ycf);
        write_reg(REG_MOTOR_COUNT, 64'(mc));
        write_reg(REG_DRIVE_MIN, 64'(mn));
        write_reg(REG_DRIVE_MAX, 64'(mx));
        write_reg(REG_STICK_THRESHOLD, 64'(th));
        write_reg(REG_UNIT_SCALE, 64'(sc));
        write_reg(REG_ROLL_COEFS, rcf);
        write_reg(REG_PITCH_COEFS, pcf);
        write_reg(REG_YAW_COEFS, ycf);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_drives.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_coefs();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic signed [15:0] rand_cosine();
        case ($urandom_range(0, 5))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            2:       return 16'sd0;
            3:       return 16'($urandom_range(12000, 16384));
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_demand();
        if ($urandom_range(0, 9) < 7)
            return 16'(int'($urandom_range(0, 6000)) - 3000);
        return 16'($urandom());
    endfunction

    function automatic mixer_item_t rand_item();
        mixer_item_t it;
        it.armed = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) < 7)
            it.stick = 13'($urandom_range(0, 4095));
        else
            it.stick = 13'($urandom());
        it.roll_cos = rand_cosine();
        it.pitch_cos = rand_cosine();
        it.roll_dem = rand_demand();
        it.pitch_dem = rand_demand();
        it.yaw_dem = rand_demand();
        it.climb_dem = rand_demand();
        return it;
    endfunction

    task automatic queue_random(int count);
        repeat (count) pending_items.push_back(rand_item());
    endtask

    initial
    begin
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        mix_cfg = '{4'd4, 12'd0, 12'd2000, 13'sd0, 8'd10, 64'd0, 64'd0, 64'd0};
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // two items on the reset settings
        pending_items.push_back('{1'b1, 13'sd500, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
                                  16'sd0, 16'sd0});
        pending_items.push_back('{1'b0, 13'sd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        wait_drained();

        set_mixer(4, 100, 2000, 200, 10, 64'h00000000_c0c04040,
                  64'h00000000_40c0c040, 64'h00000000_c040c040);
        // directed: threshold, cosine corners, demand extremes and the fitting branches
        pending_items.push_back('{1'b1, 13'sd199, 16'sd16384, 16'sd16384, 16'sd256, 16'sd256,
                                  16'sd256, 16'sd256});
        pending_items.push_back('{1'b1, 13'sd200, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
                                  16'sd0, 16'sd0});
        pending_items.push_back('{1'b1, 13'sd4095, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_items.push_back('{1'b1, -13'sd4096, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
                                  16'sd0, 16'sd0});
        pending_items.push_back('{1'b1, 13'sd1000, -16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
                                  16'sd0, 16'sd0});
        pending_items.push_back('{1'b1, 13'sd1000, 16'sd1, 16'sd16384, 16'sd0, 16'sd0,
                                  16'sd0, 16'sd0});
        pending_items.push_back('{1'b1, 13'sd1000, 16'sd11585, -16'sd1, 16'sd0, 16'sd0,
                                  16'sd0, 16'sd0});
        pending_items.push_back('{1'b1, 13'sd1500, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
                                  16'sd0, 16'sh7fff});
        pending_items.push_back('{1'b1, 13'sd1900, 16'sd16384, 16'sd16384, 16'sh7fff,
                                  -16'sd32768, 16'sh7fff, 16'sd1000});
        pending_items.push_back('{1'b1, 13'sd1500, 16'sd16384, 16'sd16384, -16'sd32768,
                                  16'sh7fff, -16'sd32768, -16'sd32768});
        pending_items.push_back('{1'b1, 13'sd100, 16'sd16384, 16'sd16384, 16'sd5000,
                                  16'sd5000, 16'sd5000, 16'sd5000});
        pending_items.push_back('{1'b0, -13'sd4096, -16'sd16384, -16'sd16384, -16'sd32768,
                                  -16'sd32768, -16'sd32768, -16'sd32768});
        pending_items.push_back('{1'b1, 13'sd4095, 16'sd16384, 16'sd16384, 16'sh7fff,
                                  16'sh7fff, 16'sh7fff, 16'sh7fff});
        wait_drained();

        // random phases, extremes of each register among them
        no_idle = 1;
        queue_random(50);
        wait_drained();
        no_idle = 0;
        set_mixer(8, 0, 4095, -4096, 255, 64'h80808080_80808080,
                  64'h7f7f7f7f_7f7f7f7f, 64'h807f807f_807f807f);
        queue_random(50);
        wait_drained();
        set_mixer(1, 4095, 1, 4095, 0, rand_coefs(), rand_coefs(), rand_coefs());
        queue_random(30);
        wait_drained();
        set_mixer(0, 300, 0, 0, 40, rand_coefs(), rand_coefs(), rand_coefs());
        queue_random(30);
        wait_drained();
        set_mixer(15, 50, 1500, 100, 20, rand_coefs(), rand_coefs(), rand_coefs());
        queue_random(60);
        wait_drained();
        set_mixer(6, 200, 2500, -100, 100, rand_coefs(), rand_coefs(), rand_coefs());
        queue_random(60);
        wait_drained();
        set_mixer(3, 2500, 1200, 50, 1, rand_coefs(), rand_coefs(), rand_coefs());
        queue_random(40);
        wait_drained();
        for (int p = 0; p < 3; p++)
        begin
            no_idle = (p == 1);
            set_mixer($urandom_range(1, 8), $urandom_range(0, 400), $urandom_range(800, 4095),
                      int'($urandom_range(0, 600)) - 300, $urandom_range(1, 255),
                      rand_coefs(), rand_coefs(), rand_coefs());
            queue_random(30);
            wait_drained();
        end

        $display("mixed %0d items into %0d motor beats over eleven register settings",
                 items_sent, beats_checked);
        $display("settings spanned motor counts 0 to 15, floor above ceiling and zero ceiling");
        if (mismatch_count == 0 && expected_drives.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[multirotor_motor_mixer_unit.f]
src/mmm_pkg.sv
src/mmm_div.sv
src/mmm_cfg.sv
src/multirotor_motor_mixer_unit.sv
verif/tb_multirotor_motor_mixer_unit.sv
